/* src/blu_pkg.sv */
// ----------------------------------------------------------------------------
// blu_pkg
// Shared types, request codes and Q16.16 arithmetic helpers for the banded
// LU solver.
// ----------------------------------------------------------------------------
package blu_pkg;

  localparam int IDX_W     = 4;
  localparam int CNT_W     = 5;
  localparam int DIV_STEPS = 48;

  localparam logic signed [31:0] Q_MAX = 32'sh7FFF_FFFF;
  localparam logic signed [31:0] Q_MIN = 32'sh8000_0000;

  localparam logic [2:0] REQ_WR_MAT = 3'd0;
  localparam logic [2:0] REQ_WR_RHS = 3'd1;
  localparam logic [2:0] REQ_FACTOR = 3'd2;
  localparam logic [2:0] REQ_SOLVE  = 3'd3;
  localparam logic [2:0] REQ_CLEAR  = 3'd4;

  localparam logic [1:0] CFG_LOWER_BW = 2'd0;
  localparam logic [1:0] CFG_UPPER_BW = 2'd1;
  localparam logic [1:0] CFG_PIV_EPS  = 2'd2;

  typedef struct packed {
    logic              start;
    logic signed [31:0] dvd;
    logic signed [31:0] dvs;
  } div_req_t;

  typedef struct packed {
    logic              done;
    logic signed [31:0] quo;
  } div_rsp_t;

  function automatic logic [31:0] qabs(input logic signed [31:0] a);
    return a[31] ? (~a + 32'd1) : a;
  endfunction

  function automatic logic signed [31:0] sat64(input logic signed [63:0] v);
    if (v[63:31] == {33{v[63]}}) return v[31:0];
    return v[63] ? Q_MIN : Q_MAX;
  endfunction

  // Round to nearest, ties toward +inf, then saturate.
  function automatic logic signed [31:0] qround(input logic signed [63:0] p);
    logic signed [63:0] s;
    s = p + 64'sd32768;
    return sat64(s >>> 16);
  endfunction

  function automatic logic signed [31:0] qsub(input logic signed [31:0] a,
                                              input logic signed [31:0] b);
    logic [32:0] d;
    d = {a[31], a} - {b[31], b};
    if (d[32] == d[31]) return d[31:0];
    return d[32] ? Q_MIN : Q_MAX;
  endfunction

  function automatic logic signed [31:0] div_sat(input logic [47:0] mag,
                                                 input logic        neg);
    if (neg) begin
      if (mag > 48'h0000_8000_0000) return Q_MIN;
      return ~mag[31:0] + 32'd1;
    end
    if (mag > 48'h0000_7FFF_FFFF) return Q_MAX;
    return mag[31:0];
  endfunction

endpackage

/* src/blu_div.sv */
// ----------------------------------------------------------------------------
// blu_div
// Q16.16 divider, restoring, one quotient bit per cycle, truncating toward
// zero with saturation. Division by zero saturates by the dividend sign.
// ----------------------------------------------------------------------------
module blu_div
  import blu_pkg::*;
(
  input  logic     clk,
  input  logic     rst_n,
  input  div_req_t req,
  output div_rsp_t rsp
);

  logic               busy_r;
  logic               done_r;
  logic [5:0]         cnt_r;
  logic [31:0]        rem_r;
  logic [47:0]        q_r;
  logic [31:0]        dvs_r;
  logic               neg_r;
  logic signed [31:0] quo_r;

  logic [32:0] trial;
  logic        ge;
  logic [31:0] rem_nxt;
  logic [47:0] q_nxt;

  assign trial   = {rem_r, q_r[47]};
  assign ge      = trial >= {1'b0, dvs_r};
  assign rem_nxt = ge ? 32'(trial - {1'b0, dvs_r}) : trial[31:0];
  assign q_nxt   = {q_r[46:0], ge};

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
    end else begin
      done_r <= 1'b0;
      if (req.start) begin
        if (req.dvs == '0) begin
          quo_r  <= req.dvd[31] ? Q_MIN : Q_MAX;
          done_r <= 1'b1;
        end else begin
          busy_r <= 1'b1;
          cnt_r  <= '0;
          rem_r  <= '0;
          q_r    <= {qabs(req.dvd), 16'd0};
          dvs_r  <= qabs(req.dvs);
          neg_r  <= req.dvd[31] ^ req.dvs[31];
        end
      end else if (busy_r) begin
        rem_r <= rem_nxt;
        q_r   <= q_nxt;
        cnt_r <= cnt_r + 6'd1;
        if (cnt_r == 6'(DIV_STEPS - 1)) begin
          busy_r <= 1'b0;
          done_r <= 1'b1;
          quo_r  <= div_sat(q_nxt, neg_r);
        end
      end
    end
  end

  assign rsp.done = done_r;
  assign rsp.quo  = quo_r;

endmodule

/* src/band_lu_partial_pivot_solver.sv */
// ----------------------------------------------------------------------------
// band_lu_partial_pivot_solver
// Banded LU factorization with partial row pivoting and triangular solve,
// signed Q16.16, on a sequencer around one multiplier and one divider.
// ----------------------------------------------------------------------------
// Usage: requests arrive on in_* (valid/ready). Matrix writes, rhs writes and
// clear are taken in idle and can be sent back to back; they give no result.
// A factor request returns one transfer on out_* carrying out_singular; a
// solve request returns N transfers (out_index 0..N-1, out_last on the final
// one), or a single out_singular transfer when the last factor failed.
// N = min(DIM, 16). While a factor or solve runs, in_ready is low.
// Factor: a pass over all N*N entries clears those outside the band, then
// per column a pivot search over the rows in the band, a row swap when the
// pivot row differs, and per eliminated row a division by the pivot (on the
// bit-serial divider) plus an update of each entry in the band. Solve: a
// multiply-accumulate per term in the forward and back rows, a division per
// back row, then N output beats. The divider's bit-serial loop dominates.
// Config (cfg_*) is always ready; write it only while the block is idle.
// Reset: bandwidths 1, epsilon 1, matrix reads zero, identity permutation.
// Results sit in an output register; a stalled receiver holds the sequencer
// at its output step until the transfer completes.
// ----------------------------------------------------------------------------
module band_lu_partial_pivot_solver
  import blu_pkg::*;
#(
  parameter int DIM = 16
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  output logic               in_ready,
  input  logic [2:0]         in_req_type,
  input  logic [3:0]         in_row,
  input  logic [3:0]         in_col,
  input  logic signed [31:0] in_value,
  output logic               out_valid,
  input  logic               out_ready,
  output logic [3:0]         out_index,
  output logic signed [31:0] out_value,
  output logic               out_singular,
  output logic               out_last,
  input  logic               cfg_valid,
  output logic               cfg_ready,
  input  logic [1:0]         cfg_index,
  input  logic [31:0]        cfg_data
);

  localparam int NSZ   = (DIM < 16) ? DIM : 16;
  localparam int RW    = (NSZ > 1) ? $clog2(NSZ) : 1;
  localparam int AW    = RW + IDX_W;
  localparam int DEPTH = NSZ * 16;
  localparam logic [CNT_W-1:0] NSZ_C = CNT_W'(NSZ);
  localparam logic [CNT_W-1:0] NM1   = CNT_W'(NSZ - 1);

  typedef enum logic [28:0] {
    ST_IDLE    = 29'd1 << 0,
    ST_MASK    = 29'd1 << 1,
    ST_PS_RD   = 29'd1 << 2,
    ST_PS_CMP  = 29'd1 << 3,
    ST_PS_CHK  = 29'd1 << 4,
    ST_SW_RA   = 29'd1 << 5,
    ST_SW_RB   = 29'd1 << 6,
    ST_SW_WA   = 29'd1 << 7,
    ST_SW_WB   = 29'd1 << 8,
    ST_EL_ST   = 29'd1 << 9,
    ST_EL_DIV  = 29'd1 << 10,
    ST_EL_DIVW = 29'd1 << 11,
    ST_EL_RDU  = 29'd1 << 12,
    ST_EL_RDJ  = 29'd1 << 13,
    ST_EL_SUB  = 29'd1 << 14,
    ST_EL_WL   = 29'd1 << 15,
    ST_NEXT_I  = 29'd1 << 16,
    ST_F_RES   = 29'd1 << 17,
    ST_FW_INIT = 29'd1 << 18,
    ST_FW_RD   = 29'd1 << 19,
    ST_FW_MUL  = 29'd1 << 20,
    ST_FW_ACC  = 29'd1 << 21,
    ST_BK_INIT = 29'd1 << 22,
    ST_BK_RD   = 29'd1 << 23,
    ST_BK_MUL  = 29'd1 << 24,
    ST_BK_ACC  = 29'd1 << 25,
    ST_BK_DIV  = 29'd1 << 26,
    ST_BK_DIVW = 29'd1 << 27,
    ST_EMIT    = 29'd1 << 28
  } state_t;

  state_t state_r;

  // configuration
  logic [3:0]  lower_bw_r;
  logic [3:0]  upper_bw_r;
  logic [30:0] eps_r;

  // matrix memory with per-entry valid bits
  logic [31:0]      mat_mem [DEPTH];
  logic [DEPTH-1:0] mvld_r;
  logic [31:0]      rd_data_r;
  logic             rd_vld_r;
  logic             mem_we;
  logic [AW-1:0]    mem_wa;
  logic [AW-1:0]    mem_ra;
  logic [31:0]      mem_wd;
  logic signed [31:0] rd_eff;

  logic signed [31:0] rhs_r  [NSZ];
  logic [3:0]         perm_r [NSZ];
  logic signed [31:0] y_r    [NSZ];
  logic               failed_r;

  logic [CNT_W-1:0] i_r, j_r, k_r, best_r;
  logic [31:0]      mag_r;
  logic signed [31:0] piv_r, l_r, acc_r, tmp_a_r, tmp_b_r;
  logic [3:0]       perm_a_r, perm_b_r;
  logic signed [63:0] prod_r;

  logic               out_valid_r;
  logic [3:0]         out_index_r;
  logic signed [31:0] out_value_r;
  logic               out_singular_r;
  logic               out_last_r;

  logic in_fire, out_free, clr;
  logic [5:0]       lim_sum, end_sum;
  logic [CNT_W-1:0] uw_sum, uw_c, lim_c, upd_end;
  logic [CNT_W-1:0] y_idx, p_idx;
  logic [3:0]       perm_rd;
  logic signed [31:0] y_rd, rhs_rd, mul_a, sub_a, sub_res;
  logic [31:0]      cmp_mag;
  logic             oob;
  div_req_t         dreq;
  div_rsp_t         drsp;

  function automatic logic [AW-1:0] maddr(input logic [CNT_W-1:0] r,
                                          input logic [CNT_W-1:0] c);
    return {r[RW-1:0], c[IDX_W-1:0]};
  endfunction

  assign in_ready  = (state_r == ST_IDLE);
  assign in_fire   = in_valid && in_ready;
  assign out_free  = !out_valid_r || out_ready;
  assign clr       = in_fire && (in_req_type == REQ_CLEAR);
  assign cfg_ready = 1'b1;

  // band limits for the current column
  assign lim_sum = {1'b0, i_r} + 6'(lower_bw_r);
  assign lim_c   = (lim_sum > 6'(NM1)) ? NM1 : lim_sum[CNT_W-1:0];
  assign uw_sum  = CNT_W'(lower_bw_r) + CNT_W'(upper_bw_r);
  assign uw_c    = (uw_sum > NM1) ? NM1 : uw_sum;
  assign end_sum = {1'b0, i_r} + {1'b0, uw_c};
  assign upd_end = (end_sum > 6'(NM1)) ? NM1 : end_sum[CNT_W-1:0];

  assign oob = ((j_r > k_r) && ((j_r - k_r) > CNT_W'(lower_bw_r))) ||
               ((k_r > j_r) && ((k_r - j_r) > CNT_W'(upper_bw_r)));

  assign rd_eff  = rd_vld_r ? rd_data_r : '0;
  assign cmp_mag = qabs(rd_eff);

  assign y_idx   = (state_r == ST_BK_INIT || state_r == ST_EMIT) ? i_r : k_r;
  assign y_rd    = y_r[y_idx[RW-1:0]];
  assign p_idx   = (state_r == ST_SW_RB) ? best_r : i_r;
  assign perm_rd = perm_r[p_idx[RW-1:0]];
  assign rhs_rd  = rhs_r[perm_rd[RW-1:0]];

  // shared multiply and subtract
  assign mul_a   = (state_r == ST_EL_RDJ) ? l_r : y_rd;
  assign sub_a   = (state_r == ST_EL_SUB) ? rd_eff : acc_r;
  assign sub_res = qsub(sub_a, qround(prod_r));

  always_ff @(posedge clk) begin
    prod_r <= $signed(mul_a) * $signed(rd_eff);
  end

  // shared divider
  always_comb begin
    dreq.start = (state_r == ST_EL_DIV) || (state_r == ST_BK_DIV);
    dreq.dvd   = (state_r == ST_EL_DIV) ? rd_eff : acc_r;
    dreq.dvs   = (state_r == ST_EL_DIV) ? piv_r : rd_eff;
  end

  blu_div u_div (
    .clk   (clk),
    .rst_n (rst_n),
    .req   (dreq),
    .rsp   (drsp)
  );

  // memory port steering
  always_comb begin
    mem_we = 1'b0;
    mem_wa = maddr(j_r, k_r);
    mem_wd = '0;
    mem_ra = maddr(i_r, k_r);
    case (state_r)
      ST_IDLE: begin
        mem_wa = {in_row[RW-1:0], in_col};
        mem_wd = in_value;
        mem_we = in_fire && (in_req_type == REQ_WR_MAT) &&
                 ({1'b0, in_row} < NSZ_C) && ({1'b0, in_col} < NSZ_C);
      end
      ST_MASK:  mem_we = oob;
      ST_PS_RD: mem_ra = maddr(j_r, i_r);
      ST_SW_RB: mem_ra = maddr(best_r, k_r);
      ST_SW_WA: begin
        mem_we = 1'b1;
        mem_wa = maddr(best_r, k_r);
        mem_wd = tmp_a_r;
      end
      ST_SW_WB: begin
        mem_we = 1'b1;
        mem_wa = maddr(i_r, k_r);
        mem_wd = tmp_b_r;
      end
      ST_EL_ST:  mem_ra = maddr(j_r, i_r);
      ST_EL_RDJ: mem_ra = maddr(j_r, k_r);
      ST_EL_SUB: begin
        mem_we = 1'b1;
        mem_wd = sub_res;
      end
      ST_EL_WL: begin
        mem_we = 1'b1;
        mem_wa = maddr(j_r, i_r);
        mem_wd = l_r;
      end
      ST_BK_RD: mem_ra = (k_r == NSZ_C) ? maddr(i_r, i_r) : maddr(i_r, k_r);
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (mem_we) mat_mem[mem_wa] <= mem_wd;
    rd_data_r <= mat_mem[mem_ra];
    rd_vld_r  <= mvld_r[mem_ra];
  end

  always_ff @(posedge clk) begin
    if (!rst_n || clr) begin
      mvld_r <= '0;
    end else if (mem_we) begin
      mvld_r[mem_wa] <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      lower_bw_r <= 4'd1;
      upper_bw_r <= 4'd1;
      eps_r      <= 31'd1;
    end else if (cfg_valid) begin
      case (cfg_index)
        CFG_LOWER_BW: lower_bw_r <= cfg_data[3:0];
        CFG_UPPER_BW: upper_bw_r <= cfg_data[3:0];
        CFG_PIV_EPS:  eps_r      <= cfg_data[30:0];
        default: ;
      endcase
    end
  end

  // sequencer
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      failed_r    <= 1'b0;
      out_valid_r <= 1'b0;
      for (int p = 0; p < NSZ; p++) perm_r[p] <= 4'(p);
    end else begin
      if (out_ready) out_valid_r <= 1'b0;
      case (state_r)
        ST_IDLE: begin
          if (in_fire) begin
            case (in_req_type)
              REQ_WR_RHS: begin
                if ({1'b0, in_row} < NSZ_C) rhs_r[in_row[RW-1:0]] <= in_value;
              end
              REQ_FACTOR: begin
                j_r     <= '0;
                k_r     <= '0;
                state_r <= ST_MASK;
              end
              REQ_SOLVE: begin
                i_r     <= '0;
                state_r <= failed_r ? ST_F_RES : ST_FW_INIT;
              end
              REQ_CLEAR: begin
                failed_r <= 1'b0;
                for (int p = 0; p < NSZ; p++) begin
                  perm_r[p] <= 4'(p);
                  rhs_r[p]  <= '0;
                end
              end
              default: ;
            endcase
          end
        end
        ST_MASK: begin
          if (k_r == NM1) begin
            k_r <= '0;
            if (j_r == NM1) begin
              for (int p = 0; p < NSZ; p++) perm_r[p] <= 4'(p);
              failed_r <= 1'b0;
              i_r      <= '0;
              j_r      <= '0;
              state_r  <= ST_PS_RD;
            end else begin
              j_r <= j_r + 1'b1;
            end
          end else begin
            k_r <= k_r + 1'b1;
          end
        end
        ST_PS_RD: state_r <= ST_PS_CMP;
        ST_PS_CMP: begin
          // keep the first largest magnitude
          if (j_r == i_r || cmp_mag > mag_r) begin
            mag_r  <= cmp_mag;
            best_r <= j_r;
            piv_r  <= rd_eff;
          end
          if (j_r == lim_c) begin
            state_r <= ST_PS_CHK;
          end else begin
            j_r     <= j_r + 1'b1;
            state_r <= ST_PS_RD;
          end
        end
        ST_PS_CHK: begin
          if (mag_r < {1'b0, eps_r}) begin
            failed_r <= 1'b1;
            state_r  <= ST_F_RES;
          end else if (best_r != i_r) begin
            k_r     <= '0;
            state_r <= ST_SW_RA;
          end else begin
            j_r     <= i_r + 1'b1;
            state_r <= ST_EL_ST;
          end
        end
        ST_SW_RA: begin
          perm_a_r <= perm_rd;
          state_r  <= ST_SW_RB;
        end
        ST_SW_RB: begin
          perm_b_r <= perm_rd;
          tmp_a_r  <= rd_eff;
          state_r  <= ST_SW_WA;
        end
        ST_SW_WA: begin
          tmp_b_r <= rd_eff;
          if (k_r == NM1) perm_r[best_r[RW-1:0]] <= perm_a_r;
          state_r <= ST_SW_WB;
        end
        ST_SW_WB: begin
          if (k_r == NM1) begin
            perm_r[i_r[RW-1:0]] <= perm_b_r;
            j_r     <= i_r + 1'b1;
            state_r <= ST_EL_ST;
          end else begin
            k_r     <= k_r + 1'b1;
            state_r <= ST_SW_RA;
          end
        end
        ST_EL_ST:  state_r <= (j_r > lim_c) ? ST_NEXT_I : ST_EL_DIV;
        ST_EL_DIV: state_r <= ST_EL_DIVW;
        ST_EL_DIVW: begin
          if (drsp.done) begin
            l_r     <= drsp.quo;
            k_r     <= i_r + 1'b1;
            state_r <= ST_EL_RDU;
          end
        end
        ST_EL_RDU: state_r <= (k_r > upd_end) ? ST_EL_WL : ST_EL_RDJ;
        ST_EL_RDJ: state_r <= ST_EL_SUB;
        ST_EL_SUB: begin
          k_r     <= k_r + 1'b1;
          state_r <= ST_EL_RDU;
        end
        ST_EL_WL: begin
          j_r     <= j_r + 1'b1;
          state_r <= ST_EL_ST;
        end
        ST_NEXT_I: begin
          if (i_r == NM1) begin
            state_r <= ST_F_RES;
          end else begin
            i_r     <= i_r + 1'b1;
            j_r     <= i_r + 1'b1;
            state_r <= ST_PS_RD;
          end
        end
        ST_F_RES: begin
          if (out_free) begin
            out_valid_r    <= 1'b1;
            out_index_r    <= '0;
            out_value_r    <= '0;
            out_singular_r <= failed_r;
            out_last_r     <= 1'b1;
            state_r        <= ST_IDLE;
          end
        end
        ST_FW_INIT: begin
          acc_r   <= rhs_rd;
          k_r     <= '0;
          state_r <= ST_FW_RD;
        end
        ST_FW_RD: begin
          if (k_r == i_r) begin
            y_r[i_r[RW-1:0]] <= acc_r;
            if (i_r == NM1) begin
              state_r <= ST_BK_INIT;
            end else begin
              i_r     <= i_r + 1'b1;
              state_r <= ST_FW_INIT;
            end
          end else begin
            state_r <= ST_FW_MUL;
          end
        end
        ST_FW_MUL: state_r <= ST_FW_ACC;
        ST_FW_ACC: begin
          acc_r   <= sub_res;
          k_r     <= k_r + 1'b1;
          state_r <= ST_FW_RD;
        end
        ST_BK_INIT: begin
          acc_r   <= y_rd;
          k_r     <= i_r + 1'b1;
          state_r <= ST_BK_RD;
        end
        ST_BK_RD:  state_r <= (k_r == NSZ_C) ? ST_BK_DIV : ST_BK_MUL;
        ST_BK_MUL: state_r <= ST_BK_ACC;
        ST_BK_ACC: begin
          acc_r   <= sub_res;
          k_r     <= k_r + 1'b1;
          state_r <= ST_BK_RD;
        end
        ST_BK_DIV: state_r <= ST_BK_DIVW;
        ST_BK_DIVW: begin
          if (drsp.done) begin
            y_r[i_r[RW-1:0]] <= drsp.quo;
            if (i_r == '0) begin
              state_r <= ST_EMIT;
            end else begin
              i_r     <= i_r - 1'b1;
              state_r <= ST_BK_INIT;
            end
          end
        end
        ST_EMIT: begin
          if (out_free) begin
            out_valid_r    <= 1'b1;
            out_index_r    <= i_r[IDX_W-1:0];
            out_value_r    <= y_rd;
            out_singular_r <= 1'b0;
            out_last_r     <= (i_r == NM1);
            if (i_r == NM1) begin
              state_r <= ST_IDLE;
            end else begin
              i_r <= i_r + 1'b1;
            end
          end
        end
        default: state_r <= ST_IDLE;
      endcase
    end
  end

  assign out_valid    = out_valid_r;
  assign out_index    = out_index_r;
  assign out_value    = out_value_r;
  assign out_singular = out_singular_r;
  assign out_last     = out_last_r;

endmodule
